>>> sv/caf_pkg.sv
package caf_pkg;

    // Field widths fixed by the sensor format and the angle format.
    localparam int RAW_W    = 16;
    localparam int ANGLE_W  = 32;
    localparam int HEAD_W   = 25;
    localparam int WEIGHT_W = 17;
    localparam int GAIN_W   = 16;
    localparam int CFG_W    = 25;
    localparam int CFG_IDX_W = 2;

    // Default parameter values.
    localparam int CORDIC_STEPS_DEF    = 16;
    localparam int ANGLE_FRAC_BITS_DEF = 16;

    // Arctangent table: atan(2^-i) in degrees, Q.20.
    localparam int TAB_LEN  = 24;
    localparam int TAB_FRAC = 20;
    localparam int TAB_W    = 27;
    localparam int TAB_IDX_W = 5;

    // Register map.
    localparam logic [CFG_IDX_W-1:0] REG_GYRO_STEP_GAIN        = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BLEND_WEIGHT          = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DECLINATION_OFFSET    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HEADING_SMOOTH_WEIGHT = 2'd3;

    // Register reset values.
    localparam logic [GAIN_W-1:0]          GYRO_STEP_GAIN_RST        = 16'd1468;
    localparam logic [WEIGHT_W-1:0]        BLEND_WEIGHT_RST          = 17'd64225;
    localparam logic signed [CFG_W-1:0]    DECLINATION_OFFSET_RST    = 25'sd274110;
    localparam logic [WEIGHT_W-1:0]        HEADING_SMOOTH_WEIGHT_RST = 17'd55706;

    // Unity weight, Q1.16.
    localparam logic [WEIGHT_W-1:0] W_ONE = 17'd65536;

    typedef struct packed {
        logic signed [RAW_W-1:0] gyro_x;
        logic signed [RAW_W-1:0] gyro_y;
        logic signed [RAW_W-1:0] accel_x;
        logic signed [RAW_W-1:0] accel_y;
        logic signed [RAW_W-1:0] accel_z;
        logic signed [RAW_W-1:0] mag_x;
        logic signed [RAW_W-1:0] mag_y;
    } sample_t;

    typedef struct packed {
        logic signed [ANGLE_W-1:0] pitch_angle;
        logic signed [ANGLE_W-1:0] roll_angle;
        logic [HEAD_W-1:0]         yaw_angle;
        logic [HEAD_W-1:0]         heading_smoothed;
    } result_t;

    function automatic logic [TAB_W-1:0] atan_deg(input logic [TAB_IDX_W-1:0] idx);
        logic [TAB_W-1:0] v;
        case (idx)
            5'd0:    v = 27'd47185920;
            5'd1:    v = 27'd27855475;
            5'd2:    v = 27'd14718068;
            5'd3:    v = 27'd7471121;
            5'd4:    v = 27'd3750058;
            5'd5:    v = 27'd1876857;
            5'd6:    v = 27'd938658;
            5'd7:    v = 27'd469357;
            5'd8:    v = 27'd234682;
            5'd9:    v = 27'd117342;
            5'd10:   v = 27'd58671;
            5'd11:   v = 27'd29335;
            5'd12:   v = 27'd14668;
            5'd13:   v = 27'd7334;
            5'd14:   v = 27'd3667;
            5'd15:   v = 27'd1833;
            5'd16:   v = 27'd917;
            5'd17:   v = 27'd458;
            5'd18:   v = 27'd229;
            5'd19:   v = 27'd115;
            5'd20:   v = 27'd57;
            5'd21:   v = 27'd29;
            5'd22:   v = 27'd14;
            5'd23:   v = 27'd7;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

>>> sv/complementary_attitude_filter_unit.sv
// Complementary attitude filter: pitch, roll and compass heading from one
// raw IMU sample (gyro x/y, accel x/y/z, mag x/y) per beat.
//
// Channels: sample (sample_valid / sample_stall) in, result (result_valid /
// result_stall) out. A beat moves when valid is high and stall is low.
// Registers are written through cfg_wen / cfg_index / cfg_wdata only while
// the block is idle: the user must keep to that, as the block does not
// enforce it. An index outside the map has no effect.
//
// The result beat is registered after the heading, pitch and roll atan2
// passes, the heading wrap and the eight multiply-accumulate ops. One
// sample is worked on at a time; a new one is taken only in idle. The pace
// is set by the single shared CORDIC stage, one rotation per cycle for
// three atan2 passes, and the single 34x18 multiplier for eight products.
//
// Reset clears the stored pitch, roll and smoothed heading, loads the
// register defaults and drops result_valid. A stalled result is held in the
// output register; the next sample is still taken and worked on, and its
// result waits until the held beat has gone.
module complementary_attitude_filter_unit #(
    parameter int CORDIC_STEPS    = caf_pkg::CORDIC_STEPS_DEF,
    parameter int ANGLE_FRAC_BITS = caf_pkg::ANGLE_FRAC_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,

    input  logic                            sample_valid,
    output logic                            sample_stall,
    input  caf_pkg::sample_t                sample,

    output logic                            result_valid,
    input  logic                            result_stall,
    output caf_pkg::result_t                result,

    input  logic                            cfg_wen,
    input  logic [caf_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [caf_pkg::CFG_W-1:0]       cfg_wdata
);

    // ---------------------------------------------------------------
    // Widths
    // ---------------------------------------------------------------
    localparam int IW = $clog2(CORDIC_STEPS);       // rotation counter
    localparam int CW = 27;                         // CORDIC x/y (raw << 8 plus growth)
    localparam int ZW = ANGLE_FRAC_BITS + 10;       // CORDIC angle, +-512 deg
    localparam int QX = 40;                         // angle rescale headroom
    localparam int HW = 27;                         // heading before wrap, signed
    localparam int MA = 34;                         // multiplier operand a
    localparam int MB = 18;                         // multiplier operand b
    localparam int PW = MA + MB;                    // product
    localparam int AW = PW + 2;                     // accumulator
    localparam int AW_ = caf_pkg::ANGLE_W;
    localparam int RAW_ARG_W = caf_pkg::RAW_W;

    // Table rounding from Q.20 to the CORDIC angle format.
    localparam int TS    = caf_pkg::TAB_FRAC - ANGLE_FRAC_BITS;
    localparam int T_RND = (1 << TS) >> 1;
    // Rescale of the CORDIC angle to Q16.16.
    localparam int Q_DN  = (ANGLE_FRAC_BITS >= 16) ? ANGLE_FRAC_BITS - 16 : 0;
    localparam int Q_UP  = (ANGLE_FRAC_BITS < 16) ? 16 - ANGLE_FRAC_BITS : 0;
    localparam logic signed [QX-1:0] Q_RND = QX'((1 << Q_DN) >> 1);

    localparam logic signed [ZW-1:0] Z180 = ZW'(180 * (1 << ANGLE_FRAC_BITS));

    localparam logic signed [HW-1:0] FULL_TURN = HW'(360 * 65536);
    localparam logic signed [HW-1:0] HALF_TURN = HW'(180 * 65536);

    localparam logic signed [AW-1:0] RND8  = AW'(128);
    localparam logic signed [AW-1:0] RND16 = AW'(32768);
    localparam logic signed [AW-1:0] SAT_HI = AW'(64'sd2147483647);
    localparam logic signed [AW-1:0] SAT_LO = -SAT_HI - AW'(1);

    // Sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CINIT = 3'd1;
    localparam logic [2:0] S_CITER = 3'd2;
    localparam logic [2:0] S_CDONE = 3'd3;
    localparam logic [2:0] S_HWRAP = 3'd4;
    localparam logic [2:0] S_MUL   = 3'd5;
    localparam logic [2:0] S_ACC   = 3'd6;
    localparam logic [2:0] S_OUT   = 3'd7;

    // atan2 passes
    localparam logic [1:0] PASS_HEAD  = 2'd0;
    localparam logic [1:0] PASS_PITCH = 2'd1;
    localparam logic [1:0] PASS_ROLL  = 2'd2;

    // Multiply-accumulate ops
    localparam logic [2:0] OP_GYRO_P   = 3'd0;  // old pitch + gyro_x * gain
    localparam logic [2:0] OP_GYRO_R   = 3'd1;  // old roll + gyro_y * gain
    localparam logic [2:0] OP_BLEND_PM = 3'd2;  // pitch meas * w
    localparam logic [2:0] OP_BLEND_PA = 3'd3;  //   + accel pitch * (1 - w)
    localparam logic [2:0] OP_BLEND_RM = 3'd4;
    localparam logic [2:0] OP_BLEND_RA = 3'd5;
    localparam logic [2:0] OP_SMOOTH_S = 3'd6;  // old smoothed * wh
    localparam logic [2:0] OP_SMOOTH_H = 3'd7;  //   + heading * (1 - wh)

    localparam logic [1:0] WRAP_LAST = 2'd2;    // two wraps, then fold

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic [caf_pkg::GAIN_W-1:0]        gain_reg;
    logic [caf_pkg::WEIGHT_W-1:0]      blend_w_reg;
    logic signed [caf_pkg::CFG_W-1:0]  decl_reg;
    logic [caf_pkg::WEIGHT_W-1:0]      smooth_w_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg     <= caf_pkg::GYRO_STEP_GAIN_RST;
            blend_w_reg  <= caf_pkg::BLEND_WEIGHT_RST;
            decl_reg     <= caf_pkg::DECLINATION_OFFSET_RST;
            smooth_w_reg <= caf_pkg::HEADING_SMOOTH_WEIGHT_RST;
        end
        else if (cfg_wen)
        begin
            unique case (cfg_index)
                caf_pkg::REG_GYRO_STEP_GAIN:
                    gain_reg <= cfg_wdata[caf_pkg::GAIN_W-1:0];
                caf_pkg::REG_BLEND_WEIGHT:
                    blend_w_reg <= cfg_wdata[caf_pkg::WEIGHT_W-1:0];
                caf_pkg::REG_DECLINATION_OFFSET:
                    decl_reg <= signed'(cfg_wdata);
                caf_pkg::REG_HEADING_SMOOTH_WEIGHT:
                    smooth_w_reg <= cfg_wdata[caf_pkg::WEIGHT_W-1:0];
                default:
                    ;
            endcase
        end
    end

    // Weights above one act as one.
    logic [caf_pkg::WEIGHT_W-1:0] wb;
    logic [caf_pkg::WEIGHT_W-1:0] wb_rest;
    logic [caf_pkg::WEIGHT_W-1:0] wh;
    logic [caf_pkg::WEIGHT_W-1:0] wh_rest;

    assign wb      = (blend_w_reg > caf_pkg::W_ONE) ? caf_pkg::W_ONE : blend_w_reg;
    assign wb_rest = caf_pkg::W_ONE - wb;
    assign wh      = (smooth_w_reg > caf_pkg::W_ONE) ? caf_pkg::W_ONE : smooth_w_reg;
    assign wh_rest = caf_pkg::W_ONE - wh;

    // ---------------------------------------------------------------
    // Sequencer and datapath registers
    // ---------------------------------------------------------------
    logic [2:0]                  state_reg,  state_next;
    logic [1:0]                  pass_reg,   pass_next;
    logic [IW-1:0]               cnt_reg,    cnt_next;
    logic [1:0]                  wcnt_reg,   wcnt_next;
    logic [2:0]                  op_reg,     op_next;
    logic                        res_valid_reg, res_valid_next;
    logic signed [AW_-1:0]       pitch_store_reg, pitch_store_next;
    logic signed [AW_-1:0]       roll_store_reg,  roll_store_next;
    logic [caf_pkg::HEAD_W-1:0]  smooth_store_reg, smooth_store_next;

    caf_pkg::sample_t            sample_reg, sample_next;
    logic signed [CW-1:0]        x_reg, x_next;
    logic signed [CW-1:0]        y_reg, y_next;
    logic signed [ZW-1:0]        z_reg, z_next;
    logic                        zero_reg, zero_next;
    logic signed [HW-1:0]        head_reg, head_next;
    logic signed [AW_-1:0]       pacc_reg, pacc_next;
    logic signed [AW_-1:0]       racc_reg, racc_next;
    logic signed [MA-1:0]        meas_p_reg, meas_p_next;
    logic signed [MA-1:0]        meas_r_reg, meas_r_next;
    logic signed [PW-1:0]        prod_reg, prod_next;
    logic signed [AW-1:0]        acc_reg, acc_next;
    caf_pkg::result_t            result_reg, result_next;

    // Shared CORDIC stage: one rotation per cycle.
    logic signed [CW-1:0]        dx, dy;
    logic [caf_pkg::TAB_W-1:0]   tab_ent;
    logic [caf_pkg::TAB_W:0]     t_wide;
    logic signed [ZW-1:0]        t_step;

    assign dx      = y_reg >>> cnt_reg;
    assign dy      = x_reg >>> cnt_reg;
    assign tab_ent = caf_pkg::atan_deg(caf_pkg::TAB_IDX_W'(cnt_reg));
    assign t_wide  = ({1'b0, tab_ent} + (caf_pkg::TAB_W + 1)'(T_RND)) >> TS;
    assign t_step  = signed'(ZW'(t_wide));

    // CORDIC angle to Q16.16, zero vector gives zero.
    logic signed [QX-1:0]        q_wide;
    logic signed [AW_-1:0]       q_angle;

    assign q_wide  = ((QX'(z_reg) + Q_RND) >>> Q_DN) <<< Q_UP;
    assign q_angle = zero_reg ? '0 : AW_'(q_wide);

    // Shared multiplier, registered before accumulation.
    logic signed [MA-1:0]        mul_a;
    logic signed [MB-1:0]        mul_b;
    logic signed [PW-1:0]        mul_p;

    assign mul_p = mul_a * mul_b;

    // Accumulator read-outs.
    logic signed [AW-1:0]        acc_sh16;
    logic signed [AW_-1:0]       acc_sat;
    logic signed [MA-1:0]        acc_meas;

    assign acc_sh16 = acc_reg >>> 16;
    assign acc_meas = MA'(acc_reg >>> 8);

    always_comb
    begin
        if (acc_sh16 > SAT_HI)
            acc_sat = AW_'(SAT_HI);
        else if (acc_sh16 < SAT_LO)
            acc_sat = AW_'(SAT_LO);
        else
            acc_sat = AW_'(acc_sh16);
    end

    // Handshakes
    logic sample_take;
    logic result_free;

    assign sample_stall = (state_reg != S_IDLE);
    assign sample_take  = sample_valid && !sample_stall;
    assign result_free  = !res_valid_reg || !result_stall;
    assign result_valid = res_valid_reg;
    assign result       = result_reg;

    always_comb
    begin
        logic signed [RAW_ARG_W-1:0] raw_x;
        logic signed [RAW_ARG_W-1:0] raw_y;
        logic signed [CW-1:0]        xs;
        logic signed [CW-1:0]        ys;

        state_next        = state_reg;
        pass_next         = pass_reg;
        cnt_next          = cnt_reg;
        wcnt_next         = wcnt_reg;
        op_next           = op_reg;
        res_valid_next    = res_valid_reg;
        pitch_store_next  = pitch_store_reg;
        roll_store_next   = roll_store_reg;
        smooth_store_next = smooth_store_reg;
        sample_next       = sample_reg;
        x_next            = x_reg;
        y_next            = y_reg;
        z_next            = z_reg;
        zero_next         = zero_reg;
        head_next         = head_reg;
        pacc_next         = pacc_reg;
        racc_next         = racc_reg;
        meas_p_next       = meas_p_reg;
        meas_r_next       = meas_r_reg;
        prod_next         = prod_reg;
        acc_next          = acc_reg;
        result_next       = result_reg;
        mul_a             = '0;
        mul_b             = '0;
        raw_x             = '0;
        raw_y             = '0;
        xs                = '0;
        ys                = '0;

        if (res_valid_reg && !result_stall)
            res_valid_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (sample_take)
                begin
                    sample_next = sample;
                    pass_next   = PASS_HEAD;
                    state_next  = S_CINIT;
                end
            end

            S_CINIT:
            begin
                // atan2(y, x): heading (mag_x, mag_y), pitch (accel_y, accel_z),
                // roll (accel_x, accel_z)
                unique case (pass_reg)
                    PASS_HEAD:
                    begin
                        raw_y = sample_reg.mag_x;
                        raw_x = sample_reg.mag_y;
                    end
                    PASS_PITCH:
                    begin
                        raw_y = sample_reg.accel_y;
                        raw_x = sample_reg.accel_z;
                    end
                    default:
                    begin
                        raw_y = sample_reg.accel_x;
                        raw_x = sample_reg.accel_z;
                    end
                endcase
                xs        = CW'(raw_x) <<< 8;
                ys        = CW'(raw_y) <<< 8;
                zero_next = (raw_x == '0) && (raw_y == '0);
                if (xs < 0)
                begin
                    // Left half-plane: pre-rotate by 180 degrees.
                    x_next = -xs;
                    y_next = -ys;
                    z_next = (ys >= 0) ? Z180 : -Z180;
                end
                else
                begin
                    x_next = xs;
                    y_next = ys;
                    z_next = '0;
                end
                cnt_next   = '0;
                state_next = S_CITER;
            end

            S_CITER:
            begin
                if (!y_reg[CW-1])
                begin
                    x_next = x_reg + dx;
                    y_next = y_reg - dy;
                    z_next = z_reg + t_step;
                end
                else
                begin
                    x_next = x_reg - dx;
                    y_next = y_reg + dy;
                    z_next = z_reg - t_step;
                end
                if (cnt_reg == IW'(CORDIC_STEPS - 1))
                    state_next = S_CDONE;
                else
                    cnt_next = cnt_reg + 1'b1;
            end

            S_CDONE:
            begin
                unique case (pass_reg)
                    PASS_HEAD:
                    begin
                        head_next  = HW'(q_angle) + HW'(decl_reg);
                        wcnt_next  = '0;
                        state_next = S_HWRAP;
                    end
                    PASS_PITCH:
                    begin
                        pacc_next  = q_angle;
                        pass_next  = PASS_ROLL;
                        state_next = S_CINIT;
                    end
                    default:
                    begin
                        racc_next  = q_angle;
                        op_next    = OP_GYRO_P;
                        state_next = S_MUL;
                    end
                endcase
            end

            S_HWRAP:
            begin
                if (wcnt_reg == WRAP_LAST)
                begin
                    // fold by half a turn
                    if (head_reg <= HALF_TURN)
                        head_next = head_reg + HALF_TURN;
                    else
                        head_next = head_reg - HALF_TURN;
                    pass_next  = PASS_PITCH;
                    state_next = S_CINIT;
                end
                else
                begin
                    if (head_reg < 0)
                        head_next = head_reg + FULL_TURN;
                    else if (head_reg > FULL_TURN)
                        head_next = head_reg - FULL_TURN;
                    wcnt_next = wcnt_reg + 1'b1;
                end
            end

            S_MUL:
            begin
                // Each op that starts a new sum, but the first, also picks up what the previous sum left in acc.
                unique case (op_reg)
                    OP_GYRO_P:
                    begin
                        acc_next = (AW'(pitch_store_reg) <<< 8) + RND8;
                        mul_a    = MA'(sample_reg.gyro_x);
                        mul_b    = MB'(gain_reg);
                    end
                    OP_GYRO_R:
                    begin
                        meas_p_next = acc_meas;
                        acc_next    = (AW'(roll_store_reg) <<< 8) + RND8;
                        mul_a       = MA'(sample_reg.gyro_y);
                        mul_b       = MB'(gain_reg);
                    end
                    OP_BLEND_PM:
                    begin
                        meas_r_next = acc_meas;
                        acc_next    = RND16;
                        mul_a       = meas_p_reg;
                        mul_b       = MB'(wb);
                    end
                    OP_BLEND_PA:
                    begin
                        mul_a = MA'(pacc_reg);
                        mul_b = MB'(wb_rest);
                    end
                    OP_BLEND_RM:
                    begin
                        pitch_store_next = acc_sat;
                        acc_next         = RND16;
                        mul_a            = meas_r_reg;
                        mul_b            = MB'(wb);
                    end
                    OP_BLEND_RA:
                    begin
                        mul_a = MA'(racc_reg);
                        mul_b = MB'(wb_rest);
                    end
                    OP_SMOOTH_S:
                    begin
                        roll_store_next = acc_sat;
                        acc_next        = RND16;
                        mul_a           = MA'(smooth_store_reg);
                        mul_b           = MB'(wh);
                    end
                    default:
                    begin
                        mul_a = MA'(head_reg);
                        mul_b = MB'(wh_rest);
                    end
                endcase
                prod_next  = mul_p;
                state_next = S_ACC;
            end

            S_ACC:
            begin
                acc_next = acc_reg + AW'(prod_reg);
                if (op_reg == OP_SMOOTH_H)
                    state_next = S_OUT;
                else
                begin
                    op_next    = op_reg + 1'b1;
                    state_next = S_MUL;
                end
            end

            default:
            begin
                // S_OUT: wait for a free output register
                if (result_free)
                begin
                    smooth_store_next            = acc_reg[caf_pkg::HEAD_W+15:16];
                    result_next.pitch_angle      = pitch_store_reg;
                    result_next.roll_angle       = roll_store_reg;
                    result_next.yaw_angle        = head_reg[caf_pkg::HEAD_W-1:0];
                    result_next.heading_smoothed = acc_reg[caf_pkg::HEAD_W+15:16];
                    res_valid_next               = 1'b1;
                    state_next                   = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            pass_reg         <= PASS_HEAD;
            cnt_reg          <= '0;
            wcnt_reg         <= '0;
            op_reg           <= OP_GYRO_P;
            res_valid_reg    <= 1'b0;
            pitch_store_reg  <= '0;
            roll_store_reg   <= '0;
            smooth_store_reg <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            pass_reg         <= pass_next;
            cnt_reg          <= cnt_next;
            wcnt_reg         <= wcnt_next;
            op_reg           <= op_next;
            res_valid_reg    <= res_valid_next;
            pitch_store_reg  <= pitch_store_next;
            roll_store_reg   <= roll_store_next;
            smooth_store_reg <= smooth_store_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sample_reg <= sample_next;
        x_reg      <= x_next;
        y_reg      <= y_next;
        z_reg      <= z_next;
        zero_reg   <= zero_next;
        head_reg   <= head_next;
        pacc_reg   <= pacc_next;
        racc_reg   <= racc_next;
        meas_p_reg <= meas_p_next;
        meas_r_reg <= meas_r_next;
        prod_reg   <= prod_next;
        acc_reg    <= acc_next;
        result_reg <= result_next;
    end

endmodule

>>> bench/tb.sv
module tb;

    // Q16.16 angle constants
    localparam longint DEG360_Q16 = 64'sd23592960;
    localparam longint DEG180_Q16 = 64'sd11796480;
    localparam longint W_UNITY    = 64'sd65536;
    localparam longint ANGLE_MAX  = 64'sd2147483647;
    localparam longint ANGLE_MIN  = -64'sd2147483648;

    // CORDIC works with ANGLE_FRAC_BITS fraction bits; the table is Q.20
    localparam int     ARC_FRAC     = caf_pkg::ANGLE_FRAC_BITS_DEF;
    localparam int     ARC_TAB_LEN  = 24;
    localparam int     ARC_TAB_DROP = (ARC_FRAC < 20) ? 20 - ARC_FRAC : 0;
    localparam longint ARC_HALF     = 180 * (longint'(1) << ARC_FRAC);

    // atan(2^-i) in degrees, Q.20
    longint arc_table [0:ARC_TAB_LEN-1] = '{
        47185920, 27855475, 14718068, 7471121, 3750058, 1876857, 938658, 469357,
        234682, 117342, 58671, 29335, 14668, 7334, 3667, 1833,
        917, 458, 229, 115, 57, 29, 14, 7
    };

    logic                          clk;
    logic                          rst_n        = 1'b0;
    logic                          sample_valid = 1'b0;
    logic                          sample_stall;
    caf_pkg::sample_t              sample       = '0;
    logic                          result_valid;
    logic                          result_stall = 1'b0;
    caf_pkg::result_t              result;
    logic                          cfg_wen      = 1'b0;
    logic [caf_pkg::CFG_IDX_W-1:0] cfg_index    = '0;
    logic [caf_pkg::CFG_W-1:0]     cfg_wdata    = '0;

    complementary_attitude_filter_unit DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_wen      (cfg_wen),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // Shadow of the block: register copies and filter state
    logic [caf_pkg::GAIN_W-1:0]       gain_cfg;
    logic [caf_pkg::WEIGHT_W-1:0]     blend_cfg;
    logic signed [caf_pkg::CFG_W-1:0] declination_cfg;
    logic [caf_pkg::WEIGHT_W-1:0]     smooth_cfg;
    longint                           pitch_est;
    longint                           roll_est;
    longint                           heading_avg;

    caf_pkg::sample_t pending_samples [$];
    caf_pkg::result_t expected_results [$];
    bit          beat_taken;
    int          sender_idle_pct   = 7;
    int          receiver_idle_pct = 80;
    int unsigned samples_sent;
    int unsigned results_checked;
    int unsigned settings_used;
    int unsigned mismatches;

    // Round half up: add half an LSB, then floor
    function automatic longint shift_round(longint v, int s);
        if (s == 0)
            return v;
        return (v + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    // Vectoring CORDIC on counts scaled by 256; result in Q16.16 degrees
    function automatic longint arctan2_deg(longint y_in, longint x_in);
        longint x;
        longint y;
        longint z;
        longint dx;
        longint dy;
        longint step;
        int     i;
        if (x_in == 0 && y_in == 0)
            return 0;
        x = x_in * 256;
        y = y_in * 256;
        z = 0;
        // left half plane: pre-rotate by 180 degrees
        if (x < 0)
        begin
            z = (y >= 0) ? ARC_HALF : -ARC_HALF;
            x = -x;
            y = -y;
        end
        for (i = 0; i < caf_pkg::CORDIC_STEPS_DEF && i < ARC_TAB_LEN; i++)
        begin
            dx   = y >>> i;
            dy   = x >>> i;
            step = shift_round(arc_table[i], ARC_TAB_DROP);
            if (y >= 0)
            begin
                x = x + dx;
                y = y - dy;
                z = z + step;
            end
            else
            begin
                x = x - dx;
                y = y + dy;
                z = z - step;
            end
        end
        if (ARC_FRAC >= 16)
            return shift_round(z, ARC_FRAC - 16);
        return z <<< (16 - ARC_FRAC);
    endfunction

    // Gyro-integrated angle blended with the accel tilt, saturated to 32 bits
    function automatic longint tilt_blend(longint old_angle, longint rate, longint tilt);
        longint w;
        longint gyro_angle;
        longint mix;
        w          = (blend_cfg > caf_pkg::W_ONE) ? W_UNITY : longint'(blend_cfg);
        gyro_angle = old_angle + shift_round(rate * longint'(gain_cfg), 8);
        mix        = shift_round(gyro_angle * w + tilt * (W_UNITY - w), 16);
        if (mix > ANGLE_MAX)
            mix = ANGLE_MAX;
        if (mix < ANGLE_MIN)
            mix = ANGLE_MIN;
        return mix;
    endfunction

    // One filter update: advances the shadow state, returns the result beat
    function automatic caf_pkg::result_t advance_filter(caf_pkg::sample_t s);
        caf_pkg::result_t r;
        longint  hdg;
        longint  w;
        int      k;
        hdg = arctan2_deg($signed(s.mag_x), $signed(s.mag_y)) + longint'(declination_cfg);
        // two wrap passes so a declination beyond half a turn still lands in range
        for (k = 0; k < 2; k++)
        begin
            if (hdg < 0)
                hdg = hdg + DEG360_Q16;
            else if (hdg > DEG360_Q16)
                hdg = hdg - DEG360_Q16;
        end
        if (hdg <= DEG180_Q16)
            hdg = hdg + DEG180_Q16;
        else
            hdg = hdg - DEG180_Q16;

        w = (smooth_cfg > caf_pkg::W_ONE) ? W_UNITY : longint'(smooth_cfg);
        heading_avg = ((heading_avg * w + hdg * (W_UNITY - w) + 32768) >> 16) & 64'hFFFF_FFFF;

        pitch_est = tilt_blend(pitch_est, $signed(s.gyro_x),
                               arctan2_deg($signed(s.accel_y), $signed(s.accel_z)));
        roll_est  = tilt_blend(roll_est, $signed(s.gyro_y),
                               arctan2_deg($signed(s.accel_x), $signed(s.accel_z)));

        r.pitch_angle      = (caf_pkg::ANGLE_W)'(pitch_est);
        r.roll_angle       = (caf_pkg::ANGLE_W)'(roll_est);
        r.yaw_angle        = (caf_pkg::HEAD_W)'(hdg);
        r.heading_smoothed = (caf_pkg::HEAD_W)'(heading_avg);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Sample driver. The posedge half records a taken beat and predicts
    // its result; the negedge half puts up the next beat or idles.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && sample_valid && !sample_stall)
        begin
            expected_results.push_back(advance_filter(sample));
            beat_taken = 1'b1;
            samples_sent++;
        end
    end

    always @(negedge clk)
    begin : sample_driver
        logic             next_valid;
        caf_pkg::sample_t next_beat;
        next_valid = sample_valid;
        next_beat  = sample;
        // a stalled beat is held untouched; only after it moves do we pick again
        if (!sample_valid || beat_taken)
        begin
            beat_taken = 1'b0;
            next_valid = 1'b0;
            if (rst_n && pending_samples.size() > 0 &&
                $urandom_range(99, 0) >= sender_idle_pct)
            begin
                next_beat  = pending_samples.pop_front();
                next_valid = 1'b1;
            end
        end
        sample_valid <= next_valid;
        sample       <= next_beat;
    end

    // ------------------------------------------------------------------
    // Result monitor: every beat taken is checked against the oldest
    // prediction, field by field.
    // ------------------------------------------------------------------
    task automatic check_field(string field, logic signed [32:0] want,
                               logic signed [32:0] got);
        if (got !== want)
        begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
        end
    endtask

    always @(posedge clk)
    begin : result_monitor
        caf_pkg::result_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (expected_results.size() == 0)
            begin
                mismatches++;
                $display("%0t: result beat with nothing expected, actual %h", $time, result);
            end
            else
            begin
                want = expected_results.pop_front();
                results_checked++;
                check_field("pitch_angle", $signed(want.pitch_angle), $signed(result.pitch_angle));
                check_field("roll_angle", $signed(want.roll_angle), $signed(result.roll_angle));
                check_field("yaw_angle", want.yaw_angle, result.yaw_angle);
                check_field("heading_smoothed", want.heading_smoothed, result.heading_smoothed);
            end
        end
    end

    // receiver back-pressure
    always @(negedge clk)
    begin
        result_stall <= rst_n && ($urandom_range(99, 0) < receiver_idle_pct);
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic caf_pkg::sample_t make_sample(int gx, int gy, int ax, int ay, int az,
                                                     int mx, int my);
        caf_pkg::sample_t s;
        s.gyro_x  = (caf_pkg::RAW_W)'(gx);
        s.gyro_y  = (caf_pkg::RAW_W)'(gy);
        s.accel_x = (caf_pkg::RAW_W)'(ax);
        s.accel_y = (caf_pkg::RAW_W)'(ay);
        s.accel_z = (caf_pkg::RAW_W)'(az);
        s.mag_x   = (caf_pkg::RAW_W)'(mx);
        s.mag_y   = (caf_pkg::RAW_W)'(my);
        return s;
    endfunction

    // mostly full range, with zeros, extremes and small values mixed in
    function automatic int random_raw();
        case ($urandom_range(9, 0))
            0:       return 0;
            1:       return $urandom_range(1, 0) ? 32767 : -32768;
            2:       return int'($urandom_range(64, 0)) - 32;
            default: return int'($urandom_range(65535, 0)) - 32768;
        endcase
    endfunction

    task automatic queue_random(int count);
        int n;
        for (n = 0; n < count; n++)
            pending_samples.push_back(make_sample(random_raw(), random_raw(), random_raw(),
                                                  random_raw(), random_raw(), random_raw(),
                                                  random_raw()));
    endtask

    // Hard gyro rates of fixed sign: pitch climbs and roll falls until both clip
    task automatic queue_spin(int count);
        int n;
        for (n = 0; n < count; n++)
            pending_samples.push_back(make_sample($urandom_range(32767, 30000),
                                                  -int'($urandom_range(32768, 30000)),
                                                  random_raw(), random_raw(), random_raw(),
                                                  random_raw(), random_raw()));
    endtask

    task automatic write_reg(logic [caf_pkg::CFG_IDX_W-1:0] idx,
                             logic [caf_pkg::CFG_W-1:0] data);
        @(negedge clk);
        cfg_wen   <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        case (idx)
            caf_pkg::REG_GYRO_STEP_GAIN:
                gain_cfg = data[caf_pkg::GAIN_W-1:0];
            caf_pkg::REG_BLEND_WEIGHT:
                blend_cfg = data[caf_pkg::WEIGHT_W-1:0];
            caf_pkg::REG_DECLINATION_OFFSET:
                declination_cfg = data;
            caf_pkg::REG_HEADING_SMOOTH_WEIGHT:
                smooth_cfg = data[caf_pkg::WEIGHT_W-1:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_wen <= 1'b0;
    endtask

    task automatic load_setting(logic [caf_pkg::CFG_W-1:0] gain,
                                logic [caf_pkg::CFG_W-1:0] blend,
                                logic [caf_pkg::CFG_W-1:0] decl,
                                logic [caf_pkg::CFG_W-1:0] smooth);
        write_reg(caf_pkg::REG_GYRO_STEP_GAIN, gain);
        write_reg(caf_pkg::REG_BLEND_WEIGHT, blend);
        write_reg(caf_pkg::REG_DECLINATION_OFFSET, decl);
        write_reg(caf_pkg::REG_HEADING_SMOOTH_WEIGHT, smooth);
        settings_used++;
    endtask

    // Sender holds off until every queued beat has gone and every result is back;
    // checked at the rising edge, where the driver's beat and the queues agree
    task automatic wait_drained(int settle);
        while (pending_samples.size() > 0 || sample_valid || expected_results.size() > 0)
            @(posedge clk);
        repeat (settle) @(negedge clk);
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        int round;
        gain_cfg        = caf_pkg::GYRO_STEP_GAIN_RST;
        blend_cfg       = caf_pkg::BLEND_WEIGHT_RST;
        declination_cfg = caf_pkg::DECLINATION_OFFSET_RST;
        smooth_cfg      = caf_pkg::HEADING_SMOOTH_WEIGHT_RST;
        pitch_est       = 0;
        roll_est        = 0;
        heading_avg     = 0;
        settings_used   = 1;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;

        // Phase 1: reset defaults, slow receiver
        sender_idle_pct   = 7;
        receiver_idle_pct = 80;
        // all zero: both atan2 operands zero
        pending_samples.push_back(make_sample(0, 0, 0, 0, 0, 0, 0));
        pending_samples.push_back(make_sample(32767, 32767, 32767, 32767, 32767, 32767, 32767));
        pending_samples.push_back(make_sample(-32768, -32768, -32768, -32768, -32768,
                                              -32768, -32768));
        // negative x operand with y zero (+180 pre-rotation) and y negative (-180)
        pending_samples.push_back(make_sample(0, 0, -1, 0, -1000, 0, -100));
        pending_samples.push_back(make_sample(0, 0, 5, -5, -32768, -5, -32768));
        pending_samples.push_back(make_sample(0, 0, 0, 1, -32768, 1, -32768));
        // x operand zero: straight up and straight down
        pending_samples.push_back(make_sample(100, -100, 32767, -32768, 0, 32767, 0));
        pending_samples.push_back(make_sample(-100, 100, -32768, 32767, 0, -32768, 0));
        // heading just below zero: the declination pushes it past the wrap
        pending_samples.push_back(make_sample(0, 0, 0, 0, 16384, 1, 32767));
        pending_samples.push_back(make_sample(0, 0, 0, 0, 16384, -1, 32767));
        // alternating bit patterns
        pending_samples.push_back(make_sample(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA,
                                              16'h5555, 16'hAAAA, 16'h5555));
        pending_samples.push_back(make_sample(16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555,
                                              16'hAAAA, 16'h5555, 16'hAAAA));
        // gyro extremes alone, then tiny tilts
        pending_samples.push_back(make_sample(32767, -32768, 0, 0, 16384, 0, 16384));
        pending_samples.push_back(make_sample(-32768, 32767, 0, 0, 16384, 0, 16384));
        pending_samples.push_back(make_sample(1, -1, 1, -1, 1, 1, -1));
        pending_samples.push_back(make_sample(-1, 1, -1, 1, -1, -1, 1));
        pending_samples.push_back(make_sample(0, 0, 12000, -9000, 14000, -20000, 7000));
        queue_random(60);
        wait_drained(4);

        // Phase 2: extremes, weight above one, declination far negative;
        // pure gyro integration until pitch and roll clip. Slow sender.
        load_setting(25'h000FFFF, 25'h001FFFF, 25'h1000000, 25'h0000000);
        sender_idle_pct   = 80;
        receiver_idle_pct = 7;
        queue_spin(290);
        wait_drained(4);

        // Phase 3: no idling, a few settings, each loaded with the pipe empty
        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
        for (round = 0; round < 4; round++)
        begin
            case (round)
                // zero gain and weight: the accel angle wins outright; heading frozen
                0: load_setting(25'h0000000, 25'h0000000, 25'h0FFFFFF, 25'h0010000);
                // unity blend, half-turn declination, smoothing weight above one
                1: load_setting((caf_pkg::CFG_W)'($urandom()), 25'h0010000, 25'd11796480,
                                25'h001FFFF);
                default: load_setting((caf_pkg::CFG_W)'($urandom()),
                                      (caf_pkg::CFG_W)'($urandom()),
                                      (caf_pkg::CFG_W)'($urandom()),
                                      (caf_pkg::CFG_W)'($urandom()));
            endcase
            queue_random(20);
            wait_drained(4);
        end

        wait_drained(100);
        $display("Checked %0d result beats from %0d samples over %0d register settings.",
                 results_checked, samples_sent, settings_used);
        $display("Included both-zero and left-half atan2 operands, heading wrap and angle clipping.");
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // Watchdog, far beyond the slowest legal run
    initial
    begin
        #4_000_000;
        $display("Timeout with %0d results outstanding", expected_results.size());
        $display("Verification failed");
        $finish;
    end

endmodule
